// File: rtl/light_sensor_lux_calculator_top_assert.svh
// assertion macros shared by the lux calculator checker
`ifndef LIGHT_SENSOR_LUX_CALCULATOR_TOP_ASSERT_SVH
`define LIGHT_SENSOR_LUX_CALCULATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lux calculator check failed");

// next-cycle implication, disabled while in reset
`define LSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lux calculator check failed");

`endif

// File: rtl/lsl_pkg.sv
// types and constants of the lux calculator
package lsl_pkg;

    localparam int unsigned RAW_W        = 16;
    localparam int unsigned SCALE_W      = 19;
    localparam int unsigned BASE_W       = 15;
    localparam int unsigned CH_SHIFT     = 10;
    localparam int unsigned PROD_W       = RAW_W + SCALE_W;
    localparam int unsigned CH_W         = PROD_W - CH_SHIFT;
    localparam int unsigned RATIO_FRAC_W = 9;
    localparam int unsigned RATIO_SHIFT  = RATIO_FRAC_W + 1;
    localparam int unsigned LIM_W        = 11;
    localparam int unsigned CMP_W        = CH_W + LIM_W;
    localparam int unsigned COEF_W       = 10;
    localparam int unsigned TERM_W       = CH_W + COEF_W;
    localparam int unsigned LUX_SHIFT    = 14;
    localparam int unsigned LUX_W        = 20;
    localparam int unsigned NUM_CELLS    = 7;
    localparam int unsigned GAIN_SHIFT   = 4;

    localparam logic [BASE_W-1:0] TINT0_SCALE = 15'h7517;
    localparam logic [BASE_W-1:0] TINT1_SCALE = 15'h0FE7;
    localparam logic [BASE_W-1:0] UNITY_SCALE = 15'h0400;
    localparam logic [LUX_W-1:0]  LUX_MAX     = 20'hFFFFF;

    localparam logic [LIM_W-1:0] LUX_K1C = 11'h043;
    localparam logic [COEF_W-1:0] LUX_B1C = 10'h204;
    localparam logic [COEF_W-1:0] LUX_M1C = 10'h1AD;

    typedef logic [2:0] seg_t;

    localparam seg_t SEG_LAST = 3'd7;
    localparam seg_t SEG_FIRST = 3'd0;

    localparam logic [LIM_W-1:0] SEG_LIMIT [NUM_CELLS] = '{
        LUX_K1C, 11'h085, 11'h0C8, 11'h10A, 11'h14D, 11'h19A, 11'h29A
    };
    localparam logic [COEF_W-1:0] SEG_B [8] = '{
        LUX_B1C, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000
    };
    localparam logic [COEF_W-1:0] SEG_M [8] = '{
        LUX_M1C, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000
    };

    typedef enum logic [1:0] {
        TINT_13MS  = 2'd0,
        TINT_101MS = 2'd1,
        TINT_NONE  = 2'd2,
        TINT_OFF   = 2'd3
    } lsl_tint_t;

    typedef enum logic [0:0] {
        CFG_HIGH_GAIN = 1'b0,
        CFG_INT_MODE  = 1'b1
    } lsl_cfg_idx_t;

    typedef struct packed {
        logic      high_gain;
        lsl_tint_t int_mode;
    } lsl_cfg_t;

    // one beat moving down the cell row
    typedef struct packed {
        logic [CH_W-1:0] ch0;
        logic [CH_W-1:0] ch1;
        logic            found;
        seg_t            seg;
    } lsl_beat_t;

endpackage

// File: rtl/lsl_scale.sv
// channel scaling stage feeding the segment cell row
module lsl_scale
    import lsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  lsl_cfg_t         cfg,
    input  logic             up_valid,
    output logic             up_ready,
    input  logic [RAW_W-1:0] raw0,
    input  logic [RAW_W-1:0] raw1,
    output logic             dn_valid,
    input  logic             dn_ready,
    output lsl_beat_t        dn_beat
);

    logic [BASE_W-1:0]  base;
    logic [SCALE_W-1:0] scale;
    logic [PROD_W-1:0]  prod0;
    logic [PROD_W-1:0]  prod1;
    logic               load;
    logic               valid_reg;
    logic               valid_next;
    lsl_beat_t          beat_reg;
    lsl_beat_t          beat_next;

    always_comb
    begin
        unique case (cfg.int_mode)
            TINT_13MS:  base = TINT0_SCALE;
            TINT_101MS: base = TINT1_SCALE;
            TINT_NONE:  base = UNITY_SCALE;
            TINT_OFF:   base = '0;
            default:    base = '0;
        endcase
    end

    // low gain multiplies the scale by 16
    assign scale = cfg.high_gain ? {{GAIN_SHIFT{1'b0}}, base} : {base, {GAIN_SHIFT{1'b0}}};

    assign prod0 = PROD_W'(raw0) * PROD_W'(scale);
    assign prod1 = PROD_W'(raw1) * PROD_W'(scale);

    always_comb
    begin
        beat_next.ch0   = prod0[PROD_W-1:CH_SHIFT];
        beat_next.ch1   = prod1[PROD_W-1:CH_SHIFT];
        // zero broadband means ratio zero, first segment
        beat_next.found = (beat_next.ch0 == '0);
        beat_next.seg   = beat_next.found ? SEG_FIRST : SEG_LAST;
    end

    assign load       = !valid_reg || dn_ready;
    assign up_ready   = load;
    assign valid_next = load ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

endmodule

// File: rtl/lsl_seg_cell.sv
// one breakpoint cell of the segment search row
module lsl_seg_cell
    import lsl_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    output logic      up_ready,
    input  lsl_beat_t up_beat,
    output logic      dn_valid,
    input  logic      dn_ready,
    output lsl_beat_t dn_beat
);

    // rounded ratio <= limit  <=>  ch1 * 2^10 < (2 * limit + 1) * ch0
    localparam logic [LIM_W-1:0] LIM_K = LIM_W'(2 * SEG_LIMIT[CELL_IDX] + 1);

    logic [CMP_W-1:0] lhs;
    logic [CMP_W-1:0] rhs;
    logic             hit;
    logic             load;
    logic             valid_reg;
    logic             valid_next;
    lsl_beat_t        beat_reg;
    lsl_beat_t        beat_next;

    assign lhs = CMP_W'({up_beat.ch1, {RATIO_SHIFT{1'b0}}});
    assign rhs = CMP_W'(up_beat.ch0) * CMP_W'(LIM_K);
    assign hit = !up_beat.found && (lhs < rhs);

    always_comb
    begin
        beat_next = up_beat;
        if (hit)
        begin
            beat_next.found = 1'b1;
            beat_next.seg   = seg_t'(CELL_IDX);
        end
    end

    assign load       = !valid_reg || dn_ready;
    assign up_ready   = load;
    assign valid_next = load ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            beat_reg <= beat_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_beat  = beat_reg;

endmodule

// File: rtl/lsl_lux_out.sv
// coefficient products, rounding and clamp, output register
module lsl_lux_out
    import lsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_ready,
    input  lsl_beat_t        up_beat,
    output logic             dn_valid,
    input  logic             dn_ready,
    output logic [LUX_W-1:0] lux
);

    localparam int unsigned SUM_W = TERM_W + 1;
    localparam int unsigned QUO_W = SUM_W - LUX_SHIFT;

    logic [TERM_W-1:0] pos_reg;
    logic [TERM_W-1:0] neg_reg;
    logic [TERM_W-1:0] pos_next;
    logic [TERM_W-1:0] neg_next;
    logic              va_reg;
    logic              va_next;
    logic              load_a;
    logic [SUM_W-1:0]  sum;
    logic [QUO_W-1:0]  quo;
    logic [LUX_W-1:0]  lux_reg;
    logic [LUX_W-1:0]  lux_next;
    logic              vb_reg;
    logic              vb_next;
    logic              load_b;

    assign pos_next = TERM_W'(up_beat.ch0) * TERM_W'(SEG_B[up_beat.seg]);
    assign neg_next = TERM_W'(up_beat.ch1) * TERM_W'(SEG_M[up_beat.seg]);

    assign sum = SUM_W'(pos_reg) + SUM_W'(1 << (LUX_SHIFT - 1)) - SUM_W'(neg_reg);
    assign quo = sum[SUM_W-1:LUX_SHIFT];

    always_comb
    begin
        priority if (neg_reg > pos_reg)
        begin
            lux_next = '0;
        end
        else if (quo > QUO_W'(LUX_MAX))
        begin
            lux_next = LUX_MAX;
        end
        else
        begin
            lux_next = quo[LUX_W-1:0];
        end
    end

    assign load_b   = !vb_reg || dn_ready;
    assign load_a   = !va_reg || load_b;
    assign up_ready = load_a;
    assign va_next  = load_a ? up_valid : va_reg;
    assign vb_next  = load_b ? va_reg : vb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a && up_valid)
        begin
            pos_reg <= pos_next;
            neg_reg <= neg_next;
        end
        if (load_b && va_reg)
        begin
            lux_reg <= lux_next;
        end
    end

    assign dn_valid = vb_reg;
    assign lux      = lux_reg;

endmodule

// File: rtl/light_sensor_lux_calculator_top.sv
// top level of the two-channel lux calculator
// stages from an accepted input beat to its result beat:
// one scaling stage, seven breakpoint cells, product stage, rounding stage
// throughput: one beat per cycle while out_ready stays high; every stage has its own valid, so bubbles close up
// reset: rst_n asynchronous active low clears all valid bits, high_gain to 0,
// integration_mode to 2 (unscaled); payload registers are not reset
module light_sensor_lux_calculator_top
    import lsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [RAW_W-1:0] broadband_count,
    input  logic [RAW_W-1:0] infrared_count,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [LUX_W-1:0] lux_value,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [0:0]       cfg_index,
    input  logic [1:0]       cfg_data
);

    logic      high_gain_reg;
    logic      high_gain_next;
    lsl_tint_t int_mode_reg;
    lsl_tint_t int_mode_next;
    lsl_cfg_t  cfg;

    // link k runs into cell k; link NUM_CELLS runs into the output stage
    logic      link_valid [NUM_CELLS+1];
    logic      link_ready [NUM_CELLS+1];
    lsl_beat_t link_beat  [NUM_CELLS+1];

    // config port never stalls; the user must write only while the pipe is idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        high_gain_next = high_gain_reg;
        int_mode_next  = int_mode_reg;
        if (cfg_valid)
        begin
            unique case (lsl_cfg_idx_t'(cfg_index))
                CFG_HIGH_GAIN: high_gain_next = cfg_data[0];
                CFG_INT_MODE:  int_mode_next  = lsl_tint_t'(cfg_data);
                default:       high_gain_next = high_gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_gain_reg <= 1'b0;
            int_mode_reg  <= TINT_NONE;
        end
        else
        begin
            high_gain_reg <= high_gain_next;
            int_mode_reg  <= int_mode_next;
        end
    end

    assign cfg.high_gain = high_gain_reg;
    assign cfg.int_mode  = int_mode_reg;

    // scale both counts, mark zero broadband as first segment
    lsl_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (in_valid),
        .up_ready (in_ready),
        .raw0     (broadband_count),
        .raw1     (infrared_count),
        .dn_valid (link_valid[0]),
        .dn_ready (link_ready[0]),
        .dn_beat  (link_beat[0])
    );

    // row of breakpoint cells: the first cell whose limit holds claims the beat
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        lsl_seg_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_beat  (link_beat[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_beat  (link_beat[k+1])
        );
    end

    // unclaimed beats keep the last segment, whose coefficients are zero
    lsl_lux_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (link_valid[NUM_CELLS]),
        .up_ready (link_ready[NUM_CELLS]),
        .up_beat  (link_beat[NUM_CELLS]),
        .dn_valid (out_valid),
        .dn_ready (out_ready),
        .lux      (lux_value)
    );

endmodule

// File: rtl/lsl_checker.sv
// port-level checker for the lux calculator and its bind
`include "light_sensor_lux_calculator_top_assert.svh"

module lsl_checker
    import lsl_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [LUX_W-1:0] lux_value,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    `LSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `LSL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(lux_value))
    // a draining output side leaves every stage free to move
    `LSL_ASSERT_NOW(a_no_stall, clk, rst_n, out_ready, in_ready)
    `LSL_ASSERT_NOW(a_cfg_open, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind light_sensor_lux_calculator_top lsl_checker u_lsl_checker (.*);

// File: dv/light_sensor_lux_calculator_top_tb.sv
// self-checking testbench for the two-channel lux calculator top level
module light_sensor_lux_calculator_top_tb;
    import lsl_pkg::*;

    // pipeline depth from accepted input beat to result beat, plus margin
    localparam int PIPE_LATENCY = 10;
    localparam int DRAIN_CYCLES = PIPE_LATENCY + 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_PER_PHASE = 140;
    localparam int NUM_PHASES = 9;
    localparam int MAX_REPORTS = 10;

    // breakpoint table of the piecewise fit, ratio in 1/512 steps
    localparam logic [11:0] RATIO_BREAK [7] = '{
        12'h043, 12'h085, 12'h0C8, 12'h10A, 12'h14D, 12'h19A, 12'h29A
    };
    localparam logic [11:0] SLOPE_B [8] = '{
        12'h204, 12'h228, 12'h253, 12'h282, 12'h177, 12'h101, 12'h037, 12'h000
    };
    localparam logic [11:0] SLOPE_M [8] = '{
        12'h1AD, 12'h2C1, 12'h363, 12'h3DF, 12'h1DD, 12'h127, 12'h02B, 12'h000
    };

    typedef struct packed {
        logic [RAW_W-1:0] bb;
        logic [RAW_W-1:0] ir;
    } sample_t;

    // clock, reset and block inputs, all known from time zero
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic [RAW_W-1:0] broadband_count = '0;
    logic [RAW_W-1:0] infrared_count = '0;
    logic             out_ready = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [0:0]       cfg_index = '0;
    logic [1:0]       cfg_data = '0;

    logic             in_ready;
    logic             out_valid;
    logic             cfg_ready;
    logic [LUX_W-1:0] lux_value;

    // shadow copy of the configuration registers
    logic       gain_shadow = 1'b0;
    lsl_tint_t  tint_shadow = TINT_NONE;

    sample_t          pending_samples [$];
    logic [LUX_W-1:0] lux_expected [$];

    int  samples_sent = 0;
    int  results_seen = 0;
    int  mismatch_count = 0;
    int  cycle_count = 0;
    int  settings_used = 1;

    // per-side idle state
    int  send_gap = 0;
    bit  send_burst = 1'b0;
    int  recv_hold = 0;
    bit  recv_burst = 1'b0;

    light_sensor_lux_calculator_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .broadband_count (broadband_count),
        .infrared_count  (infrared_count),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .lux_value       (lux_value),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // lux from one pair of raw counts under the given gain and integration time
    function automatic logic [LUX_W-1:0] predict_lux(input logic [RAW_W-1:0] bb,
                                                     input logic [RAW_W-1:0] ir,
                                                     input logic gain,
                                                     input lsl_tint_t tint);
        logic [63:0] scale;
        logic [63:0] ch0;
        logic [63:0] ch1;
        logic [63:0] ratio;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] lux;
        int          seg;
        bit          found;
        int          i;
        case (tint)
            TINT_13MS:  scale = 64'h7517;
            TINT_101MS: scale = 64'h0FE7;
            TINT_NONE:  scale = 64'd1024;
            default:    scale = 64'd0;
        endcase
        // low gain needs the extra factor of 16
        if (!gain)
            scale = scale << 4;
        ch0 = (64'(bb) * scale) >> 10;
        ch1 = (64'(ir) * scale) >> 10;
        // zero broadband falls into the first segment
        ratio = 64'd0;
        if (ch0 != 64'd0)
            ratio = (ch1 << 10) / ch0;
        ratio = (ratio + 64'd1) >> 1;
        // past the last breakpoint both slopes are zero
        seg = 7;
        found = 1'b0;
        for (i = 0; i < 7; i++)
        begin
            if (!found && ratio <= 64'(RATIO_BREAK[i]))
            begin
                seg = i;
                found = 1'b1;
            end
        end
        pos = ch0 * 64'(SLOPE_B[seg]);
        neg = ch1 * 64'(SLOPE_M[seg]);
        // negative difference clamps to zero
        if (neg > pos)
            lux = 64'd0;
        else
            lux = (pos - neg + 64'd8192) >> 14;
        if (lux > 64'hFFFFF)
            lux = 64'hFFFFF;
        return lux[LUX_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] pick_extreme();
        return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    endfunction

    // half ratio-driven pairs so every segment is hit, plus raw noise and extremes
    function automatic sample_t random_sample();
        sample_t     s;
        int unsigned kind;
        int unsigned tmp;
        kind = $urandom_range(0, 7);
        s.bb = 16'($urandom_range(0, 65535));
        s.ir = 16'($urandom_range(0, 65535));
        if (kind >= 2 && kind <= 5)
        begin
            s.bb = s.bb >> $urandom_range(0, 15);
            tmp = (int'(s.bb) * $urandom_range(0, 800)) >> 9;
            s.ir = (tmp > 65535) ? 16'hFFFF : tmp[RAW_W-1:0];
        end
        else if (kind == 6)
        begin
            s.bb = pick_extreme();
        end
        else if (kind == 7)
        begin
            s.ir = pick_extreme();
        end
        return s;
    endfunction

    task automatic push_sample(input logic [RAW_W-1:0] bb, input logic [RAW_W-1:0] ir);
        sample_t s;
        s.bb = bb;
        s.ir = ir;
        pending_samples.push_back(s);
    endtask

    // register write over the config channel, block must be idle
    task automatic write_reg(input lsl_cfg_idx_t idx, input logic [1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == CFG_HIGH_GAIN)
            gain_shadow = data[0];
        else
            tint_shadow = lsl_tint_t'(data);
    endtask

    // wait until every queued sample is sent and every result is back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || lux_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input driver: one beat per pending sample, random gaps between beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                lux_expected.push_back(predict_lux(broadband_count, infrared_count,
                                                   gain_shadow, tint_shadow));
                samples_sent++;
            end
            // beat still waiting for ready keeps valid and payload
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_samples.size() != 0)
                begin
                    sample_t s;
                    s = pending_samples.pop_front();
                    in_valid        <= 1'b1;
                    broadband_count <= s.bb;
                    infrared_count  <= s.ir;
                    // occasionally switch between back-to-back bursts and gappy traffic
                    if ($urandom_range(0, 39) == 0)
                        send_burst = !send_burst;
                    send_gap = send_burst ? 0 : $urandom_range(0, 10);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compares each beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                results_seen++;
                if (lux_expected.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result beat: lux_value=%0d", lux_value);
                end
                else
                begin
                    logic [LUX_W-1:0] want;
                    want = lux_expected.pop_front();
                    if (lux_value !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("lux_value mismatch at result %0d: expected %0d, got %0d",
                                     results_seen, want, lux_value);
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    recv_burst = !recv_burst;
                recv_hold = recv_burst ? 0 : $urandom_range(0, 10);
            end
            // stall after a beat for the drawn number of cycles
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                recv_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // stimulus sequencing: directed and random pairs under reset settings, then random phases
    initial
    begin
        logic      gain_list [NUM_PHASES-1];
        lsl_tint_t tint_list [NUM_PHASES-1];
        int        p;
        int        k;
        gain_list = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        tint_list = '{TINT_13MS, TINT_13MS, TINT_101MS, TINT_101MS,
                      TINT_NONE, TINT_OFF, TINT_OFF, TINT_NONE};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count extremes, zero broadband, single counts and bit patterns
        push_sample(16'h0000, 16'h0000);
        push_sample(16'h0000, 16'hFFFF);
        push_sample(16'hFFFF, 16'h0000);
        push_sample(16'hFFFF, 16'hFFFF);
        push_sample(16'h0001, 16'h0000);
        push_sample(16'h0000, 16'h0001);
        push_sample(16'h0001, 16'h0001);
        push_sample(16'hFFFF, 16'h0001);
        push_sample(16'hAAAA, 16'h5555);
        push_sample(16'h5555, 16'hAAAA);
        // with broadband 512 the ratio equals the infrared count: hit each breakpoint
        // and the step just past it, the last one reaching the zero-slope segment
        for (k = 0; k < 7; k++)
        begin
            push_sample(16'd512, 16'(RATIO_BREAK[k]));
            push_sample(16'd512, 16'(RATIO_BREAK[k]) + 16'd1);
        end
        for (k = 0; k < RANDOM_PER_PHASE; k++)
            pending_samples.push_back(random_sample());
        wait_idle();

        // each further phase rewrites both registers, upper data bit random on gain
        for (p = 0; p < NUM_PHASES - 1; p++)
        begin
            write_reg(CFG_HIGH_GAIN, {1'($urandom_range(0, 1)), gain_list[p]});
            write_reg(CFG_INT_MODE, tint_list[p]);
            settings_used++;
            for (k = 0; k < RANDOM_PER_PHASE; k++)
                pending_samples.push_back(random_sample());
            wait_idle();
        end

        if (lux_expected.size() != 0)
        begin
            mismatch_count += lux_expected.size();
            $display("%0d predicted results never arrived", lux_expected.size());
        end

        $display("sent %0d sample pairs over %0d gain and integration settings",
                 samples_sent, settings_used);
        $display("checked %0d lux results, %0d failures", results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
